>>> hw/rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// SIS epidemic step package
// Shared widths, opcodes and status codes.
// ----------------------------------------------------------------------------
package sis_pkg;
	localparam int MAX_NODES_DEF = 64;
	localparam int PROB_BITS_DEF = 16;
	localparam int OPC_W   = 2;
	localparam int NODE_W  = 6;
	localparam int SAMP_W  = 16;
	localparam int CNT_W   = 7;
	localparam int EDGE_W  = 11;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [OPC_W-1:0] OP_INIT   = 2'd0;
	localparam logic [OPC_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OPC_W-1:0] OP_EVAL   = 2'd2;
	localparam logic [OPC_W-1:0] OP_COMMIT = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_INIT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NODES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA = 2'd3;
endpackage

>>> hw/rtl/sis_prob_unit.sv
// ----------------------------------------------------------------------------
// SIS probability unit
// Forms p = (1-beta)^k, one truncating multiply per cycle.
// ----------------------------------------------------------------------------
module sis_prob_unit #(
	parameter int PROB_BITS = sis_pkg::PROB_BITS_DEF,
	parameter int KW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [KW-1:0]        k,
	input  logic [PROB_BITS-1:0] beta,
	output logic                 done,
	output logic [PROB_BITS:0]   p
);
	import sis_pkg::*;

	logic [PROB_BITS:0]   om;
	logic [KW-1:0]        left_q;
	logic                 busy_q;
	logic [PROB_BITS:0]   p_q;
	logic [2*PROB_BITS+1:0] prod;

	assign om   = {1'b1, {PROB_BITS{1'b0}}} - {1'b0, beta};
	assign prod = {{(PROB_BITS+1){1'b0}}, p_q} * {{(PROB_BITS+1){1'b0}}, om};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			left_q <= k;
		end else if (busy_q) begin
			if (left_q == '0 || beta == '0) begin
				busy_q <= 1'b0;
			end else begin
				left_q <= left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {1'b1, {PROB_BITS{1'b0}}};
		end else if (busy_q && left_q != '0 && beta != '0) begin
			p_q <= prod[2*PROB_BITS:PROB_BITS];
		end
	end

	assign done = busy_q && (left_q == '0 || beta == '0);
	assign p    = p_q;
endmodule

>>> hw/rtl/sis_epidemic_graph_step_top.sv
// ----------------------------------------------------------------------------
// SIS epidemic graph step
// Discrete-time SIS epidemic on a graph stored as a bit adjacency memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   opcode node_a node_b random_sample
// out      source     out_valid/out_stall status edge_added next_state
//                                         infected_count edge_count all_healthy
// cfg      sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// One request at a time. Init clears every adjacency row, one row a cycle.
// Add edge reads row a, writes it and reads row b, then writes row b; a
// duplicate ends once row a is read. Evaluate reads row a and does one
// multiply per infected neighbour (none when beta is zero). A self loop, a
// range error or an init with too many infected goes straight to the result.
// The sequencer is back in idle at the edge the result is taken; the slowest
// request is an evaluate with 63 infected neighbours.
// The adjacency memory needs no clearing after reset: a row-valid bit per row,
// cleared by reset, makes an unwritten row read as zero. Stall on the output
// holds the result; a new request is taken only once the result has gone.
// ----------------------------------------------------------------------------
module sis_epidemic_graph_step_top #(
	parameter int MAX_NODES = sis_pkg::MAX_NODES_DEF,
	parameter int PROB_BITS = sis_pkg::PROB_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sis_pkg::OPC_W-1:0]     opcode,
	input  logic [sis_pkg::NODE_W-1:0]    node_a,
	input  logic [sis_pkg::NODE_W-1:0]    node_b,
	input  logic [sis_pkg::SAMP_W-1:0]    random_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sis_pkg::STAT_W-1:0]    status,
	output logic                          edge_added,
	output logic                          next_state,
	output logic [sis_pkg::CNT_W-1:0]     infected_count,
	output logic [sis_pkg::EDGE_W-1:0]    edge_count,
	output logic                          all_healthy,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sis_pkg::CFG_DAT_W-1:0] cfg_data
);
	import sis_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int KW = NW;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_ARD   = 4'd2;
	localparam logic [3:0] S_AWA   = 4'd3;
	localparam logic [3:0] S_AWB   = 4'd4;
	localparam logic [3:0] S_ERD   = 4'd5;
	localparam logic [3:0] S_ECNT  = 4'd6;
	localparam logic [3:0] S_EMUL  = 4'd7;
	localparam logic [3:0] S_EWAIT = 4'd8;
	localparam logic [3:0] S_ECMP  = 4'd9;
	localparam logic [3:0] S_CCNT  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	// configuration
	logic [CNT_W-1:0]     nodes_q, init_q;
	logic [PROB_BITS-1:0] beta_q, delta_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= 7'd64;
			init_q  <= '0;
			beta_q  <= '0;
			delta_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NODES: nodes_q <= cfg_data[CNT_W-1:0];
				REG_INIT:  init_q  <= cfg_data[CNT_W-1:0];
				REG_BETA:  beta_q  <= PROB_BITS'(cfg_data);
				REG_DELTA: delta_q <= PROB_BITS'(cfg_data);
				default:   nodes_q <= nodes_q;
			endcase
		end
	end

	// nodes in use, clamped to MAX_NODES
	logic [NW-1:0] n_use;
	always_comb begin
		if (32'(nodes_q) > 32'(MAX_NODES)) n_use = NW'(MAX_NODES);
		else n_use = NW'(nodes_q);
	end

	// adjacency memory
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [MAX_NODES-1:0] row_ok_q;
	logic [MAX_NODES-1:0] rd_raw_s1, rd_row;
	logic                 rd_ok_s1;
	logic [IW-1:0]        rd_addr, wr_addr;
	logic                 wr_en;
	logic [MAX_NODES-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) adj_mem[wr_addr] <= wr_data;
		rd_raw_s1 <= adj_mem[rd_addr];
	end
	assign rd_row = rd_ok_s1 ? rd_raw_s1 : '0;

	// request registers
	logic [3:0]           st_q;
	logic [IW-1:0]        a_q, b_q;
	logic [PROB_BITS-1:0] samp_q;
	logic [IW-1:0]        cnt_q;
	logic [MAX_NODES-1:0] cur_q, pend_q, mask_q;
	logic [EDGE_W-1:0]    edges_q;
	logic [CNT_W-1:0]     inf_q;
	logic [STAT_W-1:0]    stat_q;
	logic                 added_q, nxt_q, ovalid_q;
	logic                 pstart;
	logic                 pdone;
	logic [PROB_BITS:0]   p_val;

	logic [MAX_NODES-1:0] in_mask;
	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) in_mask[j] = (32'(j) < 32'(n_use));
	end

	logic [MAX_NODES-1:0] nb;
	logic [KW-1:0]        k_cnt, c_cnt;
	assign nb = rd_row & cur_q & mask_q;
	always_comb begin
		k_cnt = '0;
		c_cnt = '0;
		for (int j = 0; j < MAX_NODES; j++) begin
			k_cnt = k_cnt + KW'(nb[j]);
			c_cnt = c_cnt + KW'(cur_q[j] & mask_q[j]);
		end
	end

	// the neighbour count is taken straight from the row in hand at start
	sis_prob_unit #(.PROB_BITS(PROB_BITS), .KW(KW)) u_prob (
		.clk(clk), .arst_n(arst_n), .start(pstart), .k(k_cnt), .beta(beta_q),
		.done(pdone), .p(p_val)
	);

	logic [2*PROB_BITS:0] rec_prod;
	logic [PROB_BITS:0]   thr;
	assign rec_prod = {{(PROB_BITS+1){1'b0}}, delta_q} * {{PROB_BITS{1'b0}}, p_val};
	assign thr = cur_q[a_q] ? rec_prod[2*PROB_BITS:PROB_BITS] : p_val;

	logic [PROB_BITS:0] thr_s1;
	logic               accept;
	logic [PROB_BITS-1:0] samp_in;
	assign samp_in  = PROB_BITS'(random_sample);
	assign in_stall = (st_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign pstart   = (st_q == S_ECNT);

	// add edge: S_ARD fetches row a; S_AWA sets bit b in row a unless the edge
	// is already there and fetches row b; S_AWB sets bit a in row b
	always_comb begin
		rd_addr = a_q;
		wr_en   = 1'b0;
		wr_addr = a_q;
		wr_data = rd_row | (MAX_NODES'(1) << b_q);
		unique case (st_q)
			S_AWA: begin
				rd_addr = b_q;
				wr_en   = !rd_row[b_q];
			end
			S_AWB: begin
				wr_en   = 1'b1;
				wr_addr = b_q;
				wr_data = rd_row | (MAX_NODES'(1) << a_q);
			end
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = '0;
			end
			default: rd_addr = a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ovalid_q <= 1'b0;
			row_ok_q <= '0;
			rd_ok_s1 <= 1'b0;
			cur_q    <= '0;
			pend_q   <= '0;
			edges_q  <= '0;
			inf_q    <= '0;
		end else begin
			rd_ok_s1 <= row_ok_q[rd_addr];
			if (wr_en) row_ok_q[wr_addr] <= 1'b1;
			unique case (st_q)
				S_IDLE: if (accept) begin
					a_q     <= IW'(node_a);
					b_q     <= IW'(node_b);
					samp_q  <= samp_in;
					mask_q  <= in_mask;
					added_q <= 1'b0;
					nxt_q   <= 1'b0;
					cnt_q   <= '0;
					priority if (opcode == OP_INIT) begin
						if (32'(init_q) > 32'(n_use)) begin
							stat_q <= ST_INIT;
							st_q   <= S_OUT;
						end else begin
							stat_q <= ST_OK;
							st_q   <= S_CLR;
						end
					end else if (opcode == OP_ADD) begin
						if (32'(node_a) >= 32'(n_use) || 32'(node_b) >= 32'(n_use)) begin
							stat_q <= ST_RANGE;
							st_q   <= S_OUT;
						end else if (node_a == node_b) begin
							stat_q <= ST_OK;
							st_q   <= S_OUT;
						end else begin
							stat_q <= ST_OK;
							st_q   <= S_ARD;
						end
					end else if (opcode == OP_EVAL) begin
						if (32'(node_a) >= 32'(n_use)) begin
							stat_q <= ST_RANGE;
							st_q   <= S_OUT;
						end else begin
							stat_q <= ST_OK;
							st_q   <= S_ERD;
						end
					end else begin
						stat_q <= ST_OK;
						cur_q  <= pend_q;
						st_q   <= S_CCNT;
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == MAX_NODES - 1) begin
						pend_q  <= '0;
						for (int j = 0; j < MAX_NODES; j++)
							cur_q[j] <= (32'(j) < 32'(init_q));
						edges_q <= '0;
						inf_q   <= init_q;
						st_q    <= S_OUT;
					end
				end
				S_ARD: st_q <= S_AWA;
				S_AWA: begin
					if (rd_row[b_q]) st_q <= S_OUT;
					else st_q <= S_AWB;
				end
				S_AWB: begin
					added_q <= 1'b1;
					edges_q <= edges_q + 1'b1;
					st_q    <= S_OUT;
				end
				S_ERD:  st_q <= S_ECNT;
				S_ECNT: st_q <= S_EMUL;
				S_EMUL: if (pdone) begin
					thr_s1 <= thr;
					st_q   <= S_ECMP;
				end
				S_EWAIT: st_q <= S_ECMP;
				S_ECMP: begin
					nxt_q     <= ({1'b0, samp_q} > thr_s1);
					pend_q[a_q] <= ({1'b0, samp_q} > thr_s1);
					st_q      <= S_OUT;
				end
				S_CCNT: begin
					inf_q <= CNT_W'(c_cnt);
					st_q  <= S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
					end else if (!out_stall) begin
						ovalid_q <= 1'b0;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = ovalid_q;
	assign status         = stat_q;
	assign edge_added     = added_q;
	assign next_state     = nxt_q;
	assign infected_count = inf_q;
	assign edge_count     = edges_q;
	assign all_healthy    = (inf_q == '0);
endmodule

>>> dv/tb_sis_epidemic_graph_step_top.sv
// ----------------------------------------------------------------------------
// SIS epidemic graph step testbench
// Drives init, add-edge, evaluate and commit requests through the block and
// checks every result against a cycle-free model of the epidemic state. The
// requests are mostly well-formed rounds (init, edges, evaluations, commit),
// with some random noise mixed in. Configuration is changed between phases.
// ----------------------------------------------------------------------------
module tb_sis_epidemic_graph_step_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sis_pkg::*;

	localparam int NODES = 64;
	localparam logic [16:0] ONE = 17'h10000;

	typedef struct packed {
		logic [OPC_W-1:0]  op;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [SAMP_W-1:0] samp;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic              added;
		logic              nxt;
		logic [CNT_W-1:0]  inf;
		logic [EDGE_W-1:0] edges;
		logic              healthy;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPC_W-1:0] opcode = '0;
	logic [NODE_W-1:0] node_a = '0;
	logic [NODE_W-1:0] node_b = '0;
	logic [SAMP_W-1:0] random_sample = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [STAT_W-1:0] status;
	logic edge_added;
	logic next_state;
	logic [CNT_W-1:0] infected_count;
	logic [EDGE_W-1:0] edge_count;
	logic all_healthy;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	sis_epidemic_graph_step_top i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model state of the epidemic
	logic [NODES-1:0] adj [NODES];
	logic [NODES-1:0] cur_inf, next_inf;
	logic [EDGE_W-1:0] n_edges;
	logic [CNT_W-1:0] n_infected;
	logic [6:0] cfg_nodes, cfg_init;
	logic [15:0] cfg_beta, cfg_delta;

	req_t request_q[$];
	rsp_t expected_rsp_q[$];
	int fails = 0;
	int sent = 0;
	int checked = 0;
	int phases = 0;
	bit calm = 0;
	bit pause_done = 0;

	initial begin
		foreach (adj[i]) adj[i] = '0;
		cur_inf = '0;
		next_inf = '0;
		n_edges = '0;
		n_infected = '0;
		cfg_nodes = 7'd64;
		cfg_init = '0;
		cfg_beta = '0;
		cfg_delta = '0;
	end

	// Advance the model by one request and queue the result it must produce.
	function automatic void step_epidemic(req_t r);
		rsp_t e;
		int n, k;
		logic [63:0] p, thr;
		e = '0;
		n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
		case (r.op)
			OP_INIT: begin
				if (cfg_init > n) e.st = ST_INIT;
				else begin
					foreach (adj[i]) adj[i] = '0;
					next_inf = '0;
					for (int i = 0; i < NODES; i++) cur_inf[i] = (i < cfg_init);
					n_edges = '0;
					n_infected = cfg_init;
				end
			end
			OP_ADD: begin
				if (r.a >= n || r.b >= n) e.st = ST_RANGE;
				else if (r.a != r.b && !adj[r.a][r.b]) begin
					adj[r.a][r.b] = 1'b1;
					adj[r.b][r.a] = 1'b1;
					n_edges = n_edges + 1'b1;
					e.added = 1'b1;
				end
			end
			OP_EVAL: begin
				if (r.a >= n) e.st = ST_RANGE;
				else begin
					k = 0;
					for (int j = 0; j < n; j++) if (adj[r.a][j] && cur_inf[j]) k++;
					p = ONE;
					// (1-beta) equal to one leaves p untouched
					if (cfg_beta != 0)
						for (int j = 0; j < k; j++) p = (p * (ONE - cfg_beta)) >> 16;
					if (!cur_inf[r.a]) e.nxt = (r.samp > p);
					else begin
						thr = (cfg_delta * p) >> 16;
						e.nxt = (r.samp > thr);
					end
					next_inf[r.a] = e.nxt;
				end
			end
			default: begin
				cur_inf = next_inf;
				k = 0;
				for (int i = 0; i < n; i++) k += cur_inf[i];
				n_infected = k[CNT_W-1:0];
			end
		endcase
		e.inf = n_infected;
		e.edges = n_edges;
		e.healthy = (n_infected == 0);
		expected_rsp_q = {expected_rsp_q, e};
	endfunction

	// Driver: request channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			req_t r;
			if (in_valid && !in_stall) begin
				step_epidemic({opcode, node_a, node_b, random_sample});
				sent++;
			end
			if (!in_valid || !in_stall) begin
				// one pause mid-run until the block has drained completely
				if (sent >= 600 && !pause_done && expected_rsp_q.size() == 0)
					pause_done = 1;
				if (request_q.size() > 0 && (calm || $urandom_range(0, 99) >= 27)
						&& (sent < 600 || pause_done)) begin
					r = request_q.pop_front();
					opcode <= r.op;
					node_a <= r.a;
					node_b <= r.b;
					random_sample <= r.samp;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: result channel, with one long hold-off to back the block up
	int hold_cnt = 0;
	bit hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			rsp_t e;
			if (out_valid && !out_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					e = expected_rsp_q.pop_front();
					checked++;
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status); fails++;
					end
					if (edge_added !== e.added) begin
						$error("edge_added exp %0d got %0d", e.added, edge_added); fails++;
					end
					if (next_state !== e.nxt) begin
						$error("next_state exp %0d got %0d", e.nxt, next_state); fails++;
					end
					if (infected_count !== e.inf) begin
						$error("infected_count exp %0d got %0d", e.inf, infected_count);
						fails++;
					end
					if (edge_count !== e.edges) begin
						$error("edge_count exp %0d got %0d", e.edges, edge_count); fails++;
					end
					if (all_healthy !== e.healthy) begin
						$error("all_healthy exp %0d got %0d", e.healthy, all_healthy);
						fails++;
					end
				end
			end
			if (checked >= 200 && !hold_done) begin
				hold_done = 1;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 27);
			end
		end
	end

	task automatic push_req(logic [1:0] op, int a, int b, int s);
		req_t r;
		r.op = op;
		r.a = a[NODE_W-1:0];
		r.b = b[NODE_W-1:0];
		r.samp = s[SAMP_W-1:0];
		request_q = {request_q, r};
	endtask

	task automatic drain();
		do @(posedge clk);
		while (request_q.size() != 0 || in_valid || expected_rsp_q.size() != 0);
		repeat (5) @(posedge clk);
	endtask

	// cfg_valid stays high across consecutive writes; set_config drops it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_index <= idx;
		cfg_data <= val[15:0];
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_NODES: cfg_nodes = val[6:0];
			REG_INIT:  cfg_init = val[6:0];
			REG_BETA:  cfg_beta = val[15:0];
			default:   cfg_delta = val[15:0];
		endcase
	endtask

	task automatic set_config(int nc, int ni, int beta, int delta);
		drain();
		write_reg(REG_NODES, nc);
		write_reg(REG_INIT, ni);
		write_reg(REG_BETA, beta);
		write_reg(REG_DELTA, delta);
		cfg_valid <= 1'b0;
		@(posedge clk);
		phases++;
	endtask

	// Rounds of edges, evaluations and a commit, with some noise requests, after an optional init.
	task automatic gen_rounds(int n, bit with_init);
		int rounds;
		if (with_init) push_req(OP_INIT, $urandom, $urandom, $urandom);
		rounds = $urandom_range(1, 3);
		repeat (rounds) begin
			repeat ($urandom_range(0, (n * 2 > 40) ? 40 : n * 2)) begin
				if ($urandom_range(0, 9) == 0)
					push_req(OP_ADD, $urandom, $urandom, $urandom);
				else
					push_req(OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						$urandom);
			end
			repeat ($urandom_range(1, (n > 30) ? 30 : n)) begin
				if ($urandom_range(0, 9) == 0)
					push_req(2'($urandom), $urandom, $urandom, $urandom);
				else
					push_req(OP_EVAL, $urandom_range(0, n - 1), $urandom,
						($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom);
			end
			push_req(OP_COMMIT, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		int nc, ni;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: duplicates, self loops, range errors, sample extremes
		set_config(6, 2, 30000, 20000);
		push_req(OP_INIT, 0, 0, 0);
		push_req(OP_ADD, 0, 1, 0);
		push_req(OP_ADD, 1, 0, 0);
		push_req(OP_ADD, 2, 2, 0);
		push_req(OP_ADD, 6, 0, 0);
		push_req(OP_ADD, 0, 63, 0);
		push_req(OP_ADD, 1, 2, 0);
		push_req(OP_ADD, 5, 1, 0);
		push_req(OP_EVAL, 7, 0, 0);
		push_req(OP_EVAL, 63, 63, 16'hFFFF);
		push_req(OP_EVAL, 0, 0, 0);
		push_req(OP_EVAL, 1, 0, 16'hFFFF);
		push_req(OP_EVAL, 2, 0, 16'h3000);
		push_req(OP_EVAL, 5, 0, 16'h8000);
		push_req(OP_COMMIT, 0, 0, 0);
		push_req(OP_EVAL, 1, 0, 0);
		push_req(OP_EVAL, 2, 0, 0);
		push_req(OP_COMMIT, 63, 63, 16'hFFFF);

		// extremes of every register, then random settings
		set_config(64, 64, 0, 16'hFFFF);
		gen_rounds(64, 1);
		set_config(1, 1, 16'hFFFF, 0);
		gen_rounds(1, 1);
		calm = 1;
		set_config(64, 20, 8000, 40000);
		gen_rounds(64, 1);
		drain();
		calm = 0;
		set_config(10, 40, 20000, 10000);
		gen_rounds(10, 1);
		set_config(127, 5, 20000, 60000);
		gen_rounds(64, 1);
		// shrink without init: edges to nodes beyond the range stay stored
		set_config(32, 0, 12000, 30000);
		gen_rounds(32, 0);
		while (sent + request_q.size() < 1050) begin
			nc = $urandom_range(1, 64);
			ni = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, nc);
			set_config(nc, ni, $urandom_range(0, 30000), $urandom);
			gen_rounds(nc, $urandom_range(0, 4) != 0);
		end
		drain();
		repeat (100) @(posedge clk);
		$display("Checked %0d results from %0d requests over %0d configuration phases.",
			checked, sent, phases);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/sis_pkg.sv
hw/rtl/sis_prob_unit.sv
hw/rtl/sis_epidemic_graph_step_top.sv
dv/tb_sis_epidemic_graph_step_top.sv
